### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GTSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GTSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/gtsc_pkg.sv
// ----------------------------------------------------------------------------
// Gate timing speed calculator package
// Shared widths, arithmetic constants, gate pattern codes and stage types.
// ----------------------------------------------------------------------------
package gtsc_pkg;

  localparam int TICKS_PER_US = 84;

  localparam int TICK_W    = 32;
  localparam int SPACING_W = 10;
  localparam int MAG_W     = 33;
  localparam int PROD_W    = TICK_W + MAG_W;
  localparam int NUM_W     = 37;   // 1023 * 1e8 fits in 37 bits
  localparam int DEN_W     = 36;   // 12 * (2^32 - 1) fits in 36 bits
  localparam int DIV_STEPS = NUM_W;

  localparam logic [SPACING_W-1:0] SPACING_RESET = 10'd12;

  // Division of the tick difference by a constant is a multiply by a
  // rounded-up reciprocal, which is exact for every 32-bit dividend.
  localparam int DIV_ONE   = TICKS_PER_US;
  localparam int DIV_TWO   = 2 * TICKS_PER_US;
  localparam int SHIFT_ONE = TICK_W + $clog2(DIV_ONE);
  localparam int SHIFT_TWO = TICK_W + $clog2(DIV_TWO);
  localparam logic [63:0] MAGIC_ONE_WIDE =
    ((64'd1 << SHIFT_ONE) + 64'(DIV_ONE) - 64'd1) / 64'(DIV_ONE);
  localparam logic [63:0] MAGIC_TWO_WIDE =
    ((64'd1 << SHIFT_TWO) + 64'(DIV_TWO) - 64'd1) / 64'(DIV_TWO);
  localparam logic [MAG_W-1:0] MAGIC_ONE = MAGIC_ONE_WIDE[MAG_W-1:0];
  localparam logic [MAG_W-1:0] MAGIC_TWO = MAGIC_TWO_WIDE[MAG_W-1:0];

  localparam logic [NUM_W-1:0] SPEED_SCALE     = 37'd100_000_000;
  localparam logic [DEN_W-1:0] INCHES_PER_FOOT = 36'd12;

  localparam logic [1:0] PAT_ALL       = 2'd0;
  localparam logic [1:0] PAT_ONE_TWO   = 2'd1;
  localparam logic [1:0] PAT_TWO_THREE = 2'd2;
  localparam logic [1:0] PAT_ONE_THREE = 2'd3;

  typedef struct packed {
    logic [1:0] pattern;
    logic       err;
  } meta_t;

endpackage

### src/gate_timing_speed_calc.sv
// ----------------------------------------------------------------------------
// Gate timing speed calculator
// One item per cycle while no finished item waits at a stalled output.
// The 37-stage restoring divider for the speed sets the depth of the pipeline.
// Reset clears the valid bits and sets the gate spacing to 12 inches.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gate_timing_speed_calc import gtsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SPACING_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TICK_W-1:0] in_first_gate_ticks,
  input  logic [TICK_W-1:0] in_second_gate_ticks,
  input  logic [TICK_W-1:0] in_third_gate_ticks,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_gate_pattern,
  output logic [TICK_W-1:0] out_interval_us,
  output logic [TICK_W-1:0] out_speed_hundredths_fps,
  output logic              out_reading_error
);

  logic adv;

  logic [SPACING_W-1:0] spacing_r;

  // Stage 1: gate selection and wrapped difference.
  logic              s1_valid_r;
  meta_t             s1_meta_r, s1_meta_nxt;
  logic [TICK_W-1:0] s1_diff_r, s1_diff_nxt;
  logic              s1_sel_r, s1_sel_nxt;
  logic              fired1, fired2, fired3;

  // Stage 2: reciprocal multiply.
  logic              s2_valid_r;
  meta_t             s2_meta_r;
  logic              s2_sel_r;
  logic [PROD_W-1:0] s2_prod_r, s2_prod_nxt;

  // Stage 3: interval and numerator.
  logic              s3_valid_r;
  meta_t             s3_meta_r;
  logic [TICK_W-1:0] s3_interval_r, s3_interval_nxt;
  logic [NUM_W-1:0]  s3_num_r;

  // Stage 4: denominator and final error flag.
  logic              s4_valid_r;
  meta_t             s4_meta_r, s4_meta_nxt;
  logic [TICK_W-1:0] s4_interval_r;
  logic [NUM_W-1:0]  s4_num_r;
  logic [DEN_W-1:0]  s4_den_r;

  // Divider stages: one quotient bit per stage.
  logic              dv_valid_r    [DIV_STEPS];
  meta_t             dv_meta_r     [DIV_STEPS];
  logic [TICK_W-1:0] dv_interval_r [DIV_STEPS];
  logic [DEN_W-1:0]  dv_den_r      [DIV_STEPS];
  logic [DEN_W-1:0]  dv_rem_r      [DIV_STEPS];
  logic [NUM_W-1:0]  dv_nq_r       [DIV_STEPS];

  logic              out_valid_r;
  logic [1:0]        out_pattern_r;
  logic [TICK_W-1:0] out_interval_r;
  logic [TICK_W-1:0] out_speed_r, out_speed_nxt;
  logic              out_err_r;
  logic [NUM_W-1:0]  quot;

  // The whole pipeline moves unless a finished item waits at the output.
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= SPACING_RESET;
    end else if (cfg_we) begin
      spacing_r <= cfg_wdata;
    end
  end

  assign fired1 = |in_first_gate_ticks;
  assign fired2 = |in_second_gate_ticks;
  assign fired3 = |in_third_gate_ticks;

  // Both the three-gate and the one-three cases reduce to third minus first
  // over twice the gate spacing.
  always_comb begin
    s1_meta_nxt = '{pattern: PAT_ALL, err: 1'b0};
    s1_diff_nxt = '0;
    s1_sel_nxt  = 1'b0;
    if (fired1 && fired2 && fired3) begin
      s1_diff_nxt = in_third_gate_ticks - in_first_gate_ticks;
      s1_sel_nxt  = 1'b1;
    end else if (fired1 && fired2) begin
      s1_meta_nxt.pattern = PAT_ONE_TWO;
      s1_diff_nxt         = in_second_gate_ticks - in_first_gate_ticks;
    end else if (fired2 && fired3) begin
      s1_meta_nxt.pattern = PAT_TWO_THREE;
      s1_diff_nxt         = in_third_gate_ticks - in_second_gate_ticks;
    end else if (fired1 && fired3) begin
      s1_meta_nxt.pattern = PAT_ONE_THREE;
      s1_diff_nxt         = in_third_gate_ticks - in_first_gate_ticks;
      s1_sel_nxt          = 1'b1;
    end else begin
      s1_meta_nxt.err = 1'b1;
    end
  end

  assign s2_prod_nxt = PROD_W'(s1_diff_r) *
                       PROD_W'(s1_sel_r ? MAGIC_TWO : MAGIC_ONE);

  assign s3_interval_nxt = s2_sel_r ? TICK_W'(s2_prod_r >> SHIFT_TWO)
                                    : TICK_W'(s2_prod_r >> SHIFT_ONE);

  always_comb begin
    s4_meta_nxt     = s3_meta_r;
    s4_meta_nxt.err = s3_meta_r.err || (s3_interval_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meta_r     <= s1_meta_nxt;
      s1_diff_r     <= s1_diff_nxt;
      s1_sel_r      <= s1_sel_nxt;
      s2_meta_r     <= s1_meta_r;
      s2_sel_r      <= s1_sel_r;
      s2_prod_r     <= s2_prod_nxt;
      s3_meta_r     <= s2_meta_r;
      s3_interval_r <= s3_interval_nxt;
      s3_num_r      <= NUM_W'(spacing_r) * SPEED_SCALE;
      s4_meta_r     <= s4_meta_nxt;
      s4_interval_r <= s3_interval_r;
      s4_num_r      <= s3_num_r;
      s4_den_r      <= DEN_W'(s3_interval_r) * INCHES_PER_FOOT;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic              valid_in;
    meta_t             meta_in;
    logic [TICK_W-1:0] interval_in;
    logic [DEN_W-1:0]  den_in;
    logic [DEN_W-1:0]  rem_in;
    logic [NUM_W-1:0]  nq_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              take;

    if (i == 0) begin : g_head
      assign valid_in    = s4_valid_r;
      assign meta_in     = s4_meta_r;
      assign interval_in = s4_interval_r;
      assign den_in      = s4_den_r;
      assign rem_in      = '0;
      assign nq_in       = s4_num_r;
    end else begin : g_body
      assign valid_in    = dv_valid_r[i-1];
      assign meta_in     = dv_meta_r[i-1];
      assign interval_in = dv_interval_r[i-1];
      assign den_in      = dv_den_r[i-1];
      assign rem_in      = dv_rem_r[i-1];
      assign nq_in       = dv_nq_r[i-1];
    end

    // The dividend shifts out at the top while quotient bits shift in below.
    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[i] <= 1'b0;
      end else if (adv) begin
        dv_valid_r[i] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_meta_r[i]     <= meta_in;
        dv_interval_r[i] <= interval_in;
        dv_den_r[i]      <= den_in;
        dv_rem_r[i]      <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        dv_nq_r[i]       <= {nq_in[NUM_W-2:0], take};
      end
    end
  end

  assign quot = dv_nq_r[DIV_STEPS-1];

  always_comb begin
    if (dv_meta_r[DIV_STEPS-1].err) begin
      out_speed_nxt = '0;
    end else if (|quot[NUM_W-1:TICK_W]) begin
      out_speed_nxt = '1;
    end else begin
      out_speed_nxt = quot[TICK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pattern_r  <= dv_meta_r[DIV_STEPS-1].pattern;
      out_interval_r <= dv_interval_r[DIV_STEPS-1];
      out_speed_r    <= out_speed_nxt;
      out_err_r      <= dv_meta_r[DIV_STEPS-1].err;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_gate_pattern         = out_pattern_r;
  assign out_interval_us          = out_interval_r;
  assign out_speed_hundredths_fps = out_speed_r;
  assign out_reading_error        = out_err_r;

  `GTSC_ASSERT_IMP(a_good_has_interval, out_valid && !out_reading_error, out_interval_us != '0, "valid reading with zero interval")
  `GTSC_ASSERT_IMP(a_error_zero_speed, out_valid && out_reading_error, out_speed_hundredths_fps == '0, "error reading with nonzero speed")
  `GTSC_ASSERT_NXT(a_divider_drains, dv_valid_r[DIV_STEPS-1] && !in_stall, out_valid, "finished item lost at output")

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gate timing speed calculator testbench
// Sends directed and random gate count items through the calculator under
// several gate spacings and stall patterns. Each result is compared with a
// local model of the pattern, interval and speed arithmetic.
// ----------------------------------------------------------------------------
module tb_top;
  import gtsc_pkg::*;

  localparam int PIPE_LATENCY = 42;
  localparam logic [TICK_W-1:0] ONE_SPAN = TICK_W'(TICKS_PER_US);
  localparam logic [TICK_W-1:0] TWO_SPAN = TICK_W'(2 * TICKS_PER_US);

  typedef struct packed {
    logic [1:0]        pattern;
    logic [TICK_W-1:0] interval;
    logic [TICK_W-1:0] speed;
    logic              err;
  } speed_result_t;

  typedef struct packed {
    logic [TICK_W-1:0] g1;
    logic [TICK_W-1:0] g2;
    logic [TICK_W-1:0] g3;
    logic              typed;
    speed_result_t     want;
  } gate_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [SPACING_W-1:0] cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [TICK_W-1:0]    in_first_gate_ticks;
  logic [TICK_W-1:0]    in_second_gate_ticks;
  logic [TICK_W-1:0]    in_third_gate_ticks;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_gate_pattern;
  logic [TICK_W-1:0]    out_interval_us;
  logic [TICK_W-1:0]    out_speed_hundredths_fps;
  logic                 out_reading_error;

  logic [SPACING_W-1:0] spacing_model = SPACING_RESET;
  speed_result_t        pending_readings[$];
  int                   mismatches     = 0;
  int                   send_idle_pct  = 0;
  int                   recv_stall_pct = 0;
  int                   hold_cycles    = 0;

  // Rows with a typed result are read straight off the spec at a spacing of
  // 12 inches, where the speed is simply 1e8 / interval.
  gate_row_t directed_rows [20] = '{
    '{32'h0, 32'h0, 32'h0, 1'b1, '{PAT_ALL, 32'd0, 32'd0, 1'b1}},
    '{32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, '{PAT_ALL, 32'd0, 32'd0, 1'b1}},
    '{32'h0, 32'h1, 32'h0, 1'b1, '{PAT_ALL, 32'd0, 32'd0, 1'b1}},
    '{32'h0, 32'h0, 32'h8000_0000, 1'b1, '{PAT_ALL, 32'd0, 32'd0, 1'b1}},
    '{32'd1, 32'd85, 32'd0, 1'b1, '{PAT_ONE_TWO, 32'd1, 32'd100_000_000, 1'b0}},
    '{32'd0, 32'd100, 32'd21100, 1'b1, '{PAT_TWO_THREE, 32'd250, 32'd400_000, 1'b0}},
    '{32'd1000, 32'd0, 32'd1840, 1'b1, '{PAT_ONE_THREE, 32'd5, 32'd20_000_000, 1'b0}},
    '{32'd10, 32'd94, 32'd178, 1'b1, '{PAT_ALL, 32'd1, 32'd100_000_000, 1'b0}},
    '{32'd1, 32'd84, 32'd0, 1'b1, '{PAT_ONE_TWO, 32'd0, 32'd0, 1'b1}},
    '{32'd1, 32'd0, 32'd168, 1'b1, '{PAT_ONE_THREE, 32'd0, 32'd0, 1'b1}},
    '{32'd0, 32'd5, 32'd5, 1'b1, '{PAT_TWO_THREE, 32'd0, 32'd0, 1'b1}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{PAT_ALL, 32'd0, 32'd0, 1'b1}},
    '{32'hFFFF_FFFF, 32'd83, 32'd0, 1'b1, '{PAT_ONE_TWO, 32'd1, 32'd100_000_000, 1'b0}},
    '{32'd1, 32'd8401, 32'd16801, 1'b1, '{PAT_ALL, 32'd100, 32'd1_000_000, 1'b0}},
    '{32'd3, 32'd0, 32'd168_000_003, 1'b1, '{PAT_ONE_THREE, 32'd1_000_000, 32'd100, 1'b0}},
    '{32'd200, 32'd116, 32'd0, 1'b0, '0},
    '{32'd1, 32'hFFFF_FFFF, 32'd0, 1'b0, '0},
    '{32'd1, 32'd0, 32'hFFFF_FFFF, 1'b0, '0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 32'd0, 1'b0, '0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE, 1'b0, '0}
  };

  gate_timing_speed_calc dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_we                   (cfg_we),
    .cfg_wdata                (cfg_wdata),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_first_gate_ticks      (in_first_gate_ticks),
    .in_second_gate_ticks     (in_second_gate_ticks),
    .in_third_gate_ticks      (in_third_gate_ticks),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_gate_pattern         (out_gate_pattern),
    .out_interval_us          (out_interval_us),
    .out_speed_hundredths_fps (out_speed_hundredths_fps),
    .out_reading_error        (out_reading_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic speed_result_t calc_speed_reading(input logic [TICK_W-1:0] g1,
                                                       input logic [TICK_W-1:0] g2,
                                                       input logic [TICK_W-1:0] g3);
    speed_result_t     r;
    logic [TICK_W-1:0] span;
    logic [63:0]       quotient;
    r = '0;
    if (g1 != 0 && g2 != 0 && g3 != 0) begin
      r.pattern = PAT_ALL;
      span = (g2 - g1) + (g3 - g2);
      r.interval = span / TWO_SPAN;
    end else if (g1 != 0 && g2 != 0) begin
      r.pattern = PAT_ONE_TWO;
      span = g2 - g1;
      r.interval = span / ONE_SPAN;
    end else if (g2 != 0 && g3 != 0) begin
      r.pattern = PAT_TWO_THREE;
      span = g3 - g2;
      r.interval = span / ONE_SPAN;
    end else if (g1 != 0 && g3 != 0) begin
      r.pattern = PAT_ONE_THREE;
      span = g3 - g1;
      r.interval = span / TWO_SPAN;
    end else begin
      r.err = 1'b1;
      return r;
    end
    if (r.interval == 0) begin
      r.err = 1'b1;
      return r;
    end
    quotient = (64'(spacing_model) * 64'd100_000_000) / (64'(r.interval) * 64'd12);
    r.speed = (quotient > 64'hFFFF_FFFF) ? '1 : quotient[TICK_W-1:0];
    return r;
  endfunction

  function automatic logic [TICK_W-1:0] gate_step();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 6 * TICKS_PER_US);
      1:       return $urandom_range(0, 50_000 * TICKS_PER_US);
      2:       return $urandom_range(0, 2_000_000 * TICKS_PER_US);
      default: return $urandom;
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [TICK_W-1:0] want,
                             input logic [TICK_W-1:0] got);
    if (got !== want) begin
      flag_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
    end
  endtask

  // Offers one item, holding it until accepted, then records its expected result.
  task automatic offer_reading(input logic [TICK_W-1:0] g1, input logic [TICK_W-1:0] g2,
                               input logic [TICK_W-1:0] g3, input logic typed,
                               input speed_result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_first_gate_ticks  <= g1;
    in_second_gate_ticks <= g2;
    in_third_gate_ticks  <= g3;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_readings.push_back(typed ? want : calc_speed_reading(g1, g2, g3));
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);
  endtask

  task automatic run_phase(input logic [SPACING_W-1:0] spacing, input int send_pct,
                           input int recv_pct, input int n_items, input int hold);
    logic [TICK_W-1:0] g1, g2, g3, s1, s2;
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= spacing;
    @(posedge clk);
    cfg_we <= 1'b0;
    spacing_model  = spacing;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (hold > 0) hold_cycles = hold;
    repeat (n_items) begin
      if ($urandom_range(0, 99) < 20) begin
        // Unrelated counts, often out of order, with gates dropped at random.
        g1 = $urandom;
        g2 = $urandom;
        g3 = $urandom;
        if ($urandom_range(0, 2) == 0) g1 = '0;
        if ($urandom_range(0, 2) == 0) g2 = '0;
        if ($urandom_range(0, 2) == 0) g3 = '0;
      end else begin
        s1 = gate_step();
        s2 = gate_step();
        g1 = $urandom;
        g2 = g1 + s1;
        g3 = g2 + s2;
        case ($urandom_range(0, 5))
          1: g3 = '0;
          2: g1 = '0;
          3: g2 = '0;
          4: begin
            g1 = '0;
            g2 = '0;
          end
          5: begin
            g2 = '0;
            g3 = '0;
          end
          default: ;
        endcase
      end
      offer_reading(g1, g2, g3, 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, or a long hold-off that backs the pipeline up.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_readings
    speed_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        flag_mismatch("result with no item outstanding");
      end else begin
        want = pending_readings.pop_front();
        check_field("gate_pattern", TICK_W'(want.pattern), TICK_W'(out_gate_pattern));
        check_field("interval_us", want.interval, out_interval_us);
        check_field("speed_hundredths_fps", want.speed, out_speed_hundredths_fps);
        check_field("reading_error", TICK_W'(want.err), TICK_W'(out_reading_error));
      end
    end
  end

  initial begin
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    in_valid             <= 1'b0;
    in_first_gate_ticks  <= '0;
    in_second_gate_ticks <= '0;
    in_third_gate_ticks  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      offer_reading(directed_rows[i].g1, directed_rows[i].g2, directed_rows[i].g3,
                    directed_rows[i].typed, directed_rows[i].want);
    end
    run_phase(10'd1023, 35, 56, 500, 0);
    run_phase(10'd1, 56, 35, 500, 0);
    run_phase(10'd0, 0, 0, 100, 0);
    run_phase(10'd1000, 0, 0, 400, 400);
    run_phase(SPACING_W'($urandom_range(1, 1000)), 0, 0, 380, 0);
    wait_for_drain();
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Timeout, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

### gate_timing_speed_calc.f
+incdir+src
src/gtsc_pkg.sv
src/gate_timing_speed_calc.sv
dv/tb_top.sv
